/* rtl/core/wavetable_oscillator_interp_core_macros.svh */
// Assertion macros for the wavetable oscillator core.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef WAVETABLE_OSCILLATOR_INTERP_CORE_MACROS_SVH
`define WAVETABLE_OSCILLATOR_INTERP_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTOSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wtosc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WTOSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wtosc: next-cycle check failed");

`endif

/* rtl/core/wtosc_pkg.sv */
// Shared constants for the wavetable oscillator core.
// No dependencies; used by the top level and the testbench.
package wtosc_pkg;

  localparam int TABLE_SIZE_DEF  = 4096;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LEN_CFG_W = 13;
  localparam int INC_CFG_W = 28;
  localparam int CFG_W     = 28;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 1'd1;

  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 13'd4096;

  localparam logic OP_NEXT  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

endpackage

/* rtl/core/wtosc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wtosc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/wavetable_oscillator_interp_core.sv */
// Wavetable oscillator with linear interpolation, top level.
// Depends on wtosc_pkg, wtosc_ram and wavetable_oscillator_interp_core_macros.svh.
//
//   channel | direction | handshake             | payload
//   s_*     | in        | s_tvalid / s_tready   | s_tuser operation, s_tdata index, value
//   m_*     | out       | m_tvalid / m_tready   | m_tdata sample_out
//   cfg_*   | in        | cfg_we (no wait)      | cfg_index, cfg_data
//
// One item is taken per cycle while s_tready is high.
// The two table copies are read in the accept cycle, so both indices of an item
// come out of one memory access each; a multiply stage and an add stage follow.
// A four-entry output queue absorbs stalls; s_tready drops only when the queue
// and the two stages in flight would fill it. Reset is synchronous, holds s_tready
// low and leaves the table contents as they were.
`include "wavetable_oscillator_interp_core_macros.svh"

module wavetable_oscillator_interp_core #(
  parameter int TABLE_SIZE  = wtosc_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS   = wtosc_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = wtosc_pkg::SAMPLE_BITS_DEF,
  localparam int IDX_W = $clog2(TABLE_SIZE),
  localparam int IN_W  = ((IDX_W + SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [IN_W-1:0]                 s_tdata,  // write_index, write_value
  input  logic                            s_tuser,  // operation
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_W-1:0]                m_tdata,  // sample_out
  input  logic                            cfg_we,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtosc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int LEN_W = IDX_W + 1;
  localparam int PH_W  = IDX_W + FRAC_BITS;
  localparam int LW2   = (wtosc_pkg::LEN_CFG_W > LEN_W) ? wtosc_pkg::LEN_CFG_W : LEN_W;
  localparam int IW    = (wtosc_pkg::INC_CFG_W > PH_W + 1) ? wtosc_pkg::INC_CFG_W : PH_W + 1;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

  logic [wtosc_pkg::LEN_CFG_W-1:0] table_length;
  logic [wtosc_pkg::INC_CFG_W-1:0] phase_increment;
  logic [PH_W-1:0]                 phase;
  logic [PH_W-1:0]                 phase_next;

  logic                   in_accept;
  logic                   is_write;
  logic                   is_next;
  logic [IDX_W-1:0]       wr_idx;
  logic [SAMPLE_BITS-1:0] wr_val;
  logic                   wr_en;

  logic [LW2-1:0]   len_ext;
  logic [LW2-1:0]   len_sat;
  logic [LEN_W-1:0] eff_len;
  logic [PH_W:0]    lfix;
  logic [IW-1:0]    inc_ext;
  logic [IW-1:0]    lfix_ext;
  logic [PH_W-1:0]  inc_c;
  logic [PH_W-1:0]  p0;
  logic [PH_W:0]    sum;
  logic [IDX_W-1:0] i0;
  logic [LEN_W-1:0] i0p;
  logic [IDX_W-1:0] i1;

  logic [SAMPLE_BITS-1:0] v0;
  logic [SAMPLE_BITS-1:0] v1;

  logic                   s1_valid;
  logic [FRAC_BITS-1:0]   s1_frac;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PROD_W-1:0]      prod;
  logic                          s2_valid;
  logic signed [PROD_W-1:0]      s2_prod;
  logic [SAMPLE_BITS-1:0]        s2_v0;
  logic signed [PROD_W-1:0]      prod_sh;
  logic [SAMPLE_BITS-1:0]        result;

  logic [SAMPLE_BITS-1:0]              fifo_mem [wtosc_pkg::FIFO_DEPTH];
  logic [wtosc_pkg::FIFO_PTR_W-1:0]    wr_ptr;
  logic [wtosc_pkg::FIFO_PTR_W-1:0]    rd_ptr;
  logic [wtosc_pkg::FIFO_CNT_W-1:0]    fifo_count;
  logic [wtosc_pkg::FIFO_CNT_W:0]      occupancy;
  logic                                pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length    <= wtosc_pkg::LEN_RESET;
      phase_increment <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wtosc_pkg::REG_TABLE_LENGTH:    table_length    <= cfg_data[wtosc_pkg::LEN_CFG_W-1:0];
        wtosc_pkg::REG_PHASE_INCREMENT: phase_increment <= cfg_data[wtosc_pkg::INC_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_accept = s_tvalid && s_tready;
  assign is_write  = in_accept && (s_tuser == wtosc_pkg::OP_WRITE);
  assign is_next   = in_accept && (s_tuser == wtosc_pkg::OP_NEXT);
  assign wr_idx    = s_tdata[IDX_W-1:0];
  assign wr_val    = s_tdata[IDX_W +: SAMPLE_BITS];
  assign wr_en     = is_write && ({1'b0, wr_idx} < LEN_W'(TABLE_SIZE));

  // Effective length, clamped increment and phase step.
  always_comb begin
    len_ext = LW2'(table_length);
    if (len_ext < LW2'(2)) begin
      len_sat = LW2'(2);
    end else if (len_ext > LW2'(TABLE_SIZE)) begin
      len_sat = LW2'(TABLE_SIZE);
    end else begin
      len_sat = len_ext;
    end
    eff_len  = LEN_W'(len_sat);
    lfix     = {eff_len, {FRAC_BITS{1'b0}}};
    inc_ext  = IW'(phase_increment);
    lfix_ext = IW'(lfix);
    inc_c    = (inc_ext >= lfix_ext) ? PH_W'(lfix_ext - IW'(1)) : PH_W'(inc_ext);
    p0       = ({1'b0, phase} >= lfix) ? '0 : phase;
    i0       = p0[PH_W-1 -: IDX_W];
    i0p      = LEN_W'(i0) + LEN_W'(1);
    i1       = (i0p == eff_len) ? '0 : i0p[IDX_W-1:0];
    sum      = (PH_W+1)'(p0) + (PH_W+1)'(inc_c);
    phase_next = (sum >= lfix) ? PH_W'(sum - lfix) : PH_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (is_next) begin
      phase <= phase_next;
    end
  end

  // Two copies of the table so both neighbors are read in the same cycle.
  wtosc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_SIZE)) u_ram_lo (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_val),
    .re    (is_next),
    .raddr (i0),
    .rdata (v0)
  );

  wtosc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_SIZE)) u_ram_hi (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_val),
    .re    (is_next),
    .raddr (i1),
    .rdata (v1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= is_next;
    end
    if (is_next) begin
      s1_frac <= p0[FRAC_BITS-1:0];
    end
  end

  assign diff   = $signed({v1[SAMPLE_BITS-1], v1}) - $signed({v0[SAMPLE_BITS-1], v0});
  assign frac_s = $signed({1'b0, s1_frac});
  assign prod   = PROD_W'(diff) * PROD_W'(frac_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_prod <= prod;
    s2_v0   <= v0;
  end

  assign prod_sh = s2_prod >>> FRAC_BITS;
  assign result  = s2_v0 + SAMPLE_BITS'(prod_sh);

  // Output queue.
  assign pop       = m_tvalid && m_tready;
  assign m_tvalid  = (fifo_count != '0);
  assign m_tdata   = OUT_W'(fifo_mem[rd_ptr]);
  assign occupancy = (wtosc_pkg::FIFO_CNT_W+1)'(fifo_count)
                   + (wtosc_pkg::FIFO_CNT_W+1)'(s1_valid)
                   + (wtosc_pkg::FIFO_CNT_W+1)'(s2_valid);
  assign s_tready  = !rst
                   && (occupancy < (wtosc_pkg::FIFO_CNT_W+1)'(wtosc_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + wtosc_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wtosc_pkg::FIFO_PTR_W'(1);
      end
      if (s2_valid && !pop) begin
        fifo_count <= fifo_count + wtosc_pkg::FIFO_CNT_W'(1);
      end else if (!s2_valid && pop) begin
        fifo_count <= fifo_count - wtosc_pkg::FIFO_CNT_W'(1);
      end
    end
    if (s2_valid) begin
      fifo_mem[wr_ptr] <= result;
    end
  end

  `WTOSC_ASSERT_SAME(a_no_overflow, s2_valid, fifo_count < wtosc_pkg::FIFO_CNT_W'(wtosc_pkg::FIFO_DEPTH))
  `WTOSC_ASSERT_NEXT(a_write_silent, is_write, !s1_valid)
  `WTOSC_ASSERT_NEXT(a_next_reads, is_next, s1_valid)

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for wavetable_oscillator_interp_core.
// Predicts every interpolated sample from its own table and phase state, drives the
// streams with random gaps and stalls; depends on wtosc_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = wtosc_pkg::OP_NEXT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [wtosc_pkg::CFG_IDX_W-1:0] cfg_index = wtosc_pkg::REG_TABLE_LENGTH;
  logic [wtosc_pkg::CFG_W-1:0]     cfg_data = '0;

  logic signed [15:0] wave_table [4096];
  bit                 wave_known [4096];
  bit [28:0]          osc_phase = '0;
  bit [12:0]          length_reg = wtosc_pkg::LEN_RESET;
  bit [27:0]          step_reg = '0;
  logic signed [15:0] samples_due [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  rx_hold_left = 0;
  int  rx_burst_left = 0;
  bit  tx_bursts_on = 1'b1;
  bit  rx_bursts_on = 1'b1;

  wavetable_oscillator_interp_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_length();
    if (length_reg < 2) return 2;
    if (length_reg > 4096) return 4096;
    return length_reg;
  endfunction

  function automatic void locate_taps(output int unsigned i0, output int unsigned i1,
                                      output bit [15:0] frac);
    bit [28:0] lfix;
    bit [28:0] ph;
    lfix = 29'(active_length()) << 16;
    ph = (osc_phase >= lfix) ? 29'd0 : osc_phase;
    i0 = ph[27:16];
    i1 = (i0 + 1 >= active_length()) ? 0 : i0 + 1;
    frac = ph[15:0];
  endfunction

  function automatic void oscillate_once();
    bit [28:0]   lfix;
    bit [28:0]   inc;
    int unsigned i0, i1;
    bit [15:0]   frac;
    int          diff;
    longint      prod;
    lfix = 29'(active_length()) << 16;
    inc = {1'b0, step_reg};
    if (inc >= lfix) inc = lfix - 1;
    locate_taps(i0, i1, frac);
    if (osc_phase >= lfix) osc_phase = '0;
    diff = int'(wave_table[i1]) - int'(wave_table[i0]);
    prod = longint'(diff) * longint'(frac);
    samples_due.push_back(wave_table[i0] + 16'(prod >>> 16));
    osc_phase = osc_phase + inc;
    if (osc_phase >= lfix) osc_phase = osc_phase - lfix;
  endfunction

  task automatic offer(logic op, bit [11:0] idx, bit [15:0] val);
    if (tx_bursts_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'b0, val, idx};
    do @(posedge clk); while (!s_tready);
    if (op == wtosc_pkg::OP_WRITE) begin
      wave_table[idx] = val;
      wave_known[idx] = 1'b1;
    end else begin
      oscillate_once();
    end
  endtask

  task automatic store_sample(bit [11:0] idx, bit [15:0] val);
    offer(wtosc_pkg::OP_WRITE, idx, val);
  endtask

  // Entries that the next sample will read are filled first if still unknown.
  task automatic play_sample();
    int unsigned i0, i1;
    bit [15:0]   frac;
    locate_taps(i0, i1, frac);
    if (!wave_known[i0]) store_sample(i0, 16'($urandom));
    if (!wave_known[i1]) store_sample(i1, 16'($urandom));
    offer(wtosc_pkg::OP_NEXT, 12'($urandom), 16'($urandom));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_register(logic [wtosc_pkg::CFG_IDX_W-1:0] which,
                              logic [wtosc_pkg::CFG_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      wtosc_pkg::REG_TABLE_LENGTH: begin
        length_reg = value[12:0];
      end
      wtosc_pkg::REG_PHASE_INCREMENT: begin
        step_reg = value[27:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic test_reset_state();
    store_sample(12'd0, 16'h7FFF);
    store_sample(12'd1, 16'h8000);
    store_sample(12'd4095, 16'h5A5A);
    repeat (2) play_sample();
  endtask

  task automatic test_interpolation();
    set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd4);
    store_sample(12'd0, 16'h8000);
    store_sample(12'd1, 16'h7FFF);
    store_sample(12'd2, 16'h0000);
    store_sample(12'd3, 16'h7FFF);
    set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'h000C000);
    repeat (6) play_sample();
    set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'h000FFFF);
    repeat (3) play_sample();
  endtask

  task automatic test_length_limits();
    set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'hFFFFFFF);
    set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd0);
    repeat (2) play_sample();
    set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd1);
    repeat (2) play_sample();
    set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd8191);
    repeat (2) play_sample();
  endtask

  task automatic test_increment_clamp();
    set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd5);
    set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'h0050000);
    repeat (3) play_sample();
    set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'h004FFFF);
    repeat (2) play_sample();
  endtask

  task automatic test_phase_restart();
    set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd4096);
    set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'h0408000);
    repeat (3) play_sample();
    set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd16);
    repeat (2) play_sample();
  endtask

  task automatic test_output_stall();
    set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'h0013A5C);
    rx_hold_left <= 300;
    repeat (40) play_sample();
    settle();
  endtask

  task automatic test_random_phases();
    int unsigned pick;
    for (int phase_no = 0; phase_no < 18; phase_no++) begin
      if (phase_no == 14) begin
        tx_bursts_on = 1'b0;
        rx_bursts_on = 1'b0;
      end
      pick = $urandom_range(0, 11);
      case (pick)
        0: set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd0);
        1: set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'd4096);
        2: set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'($urandom_range(0, 8191)));
        default: set_register(wtosc_pkg::REG_TABLE_LENGTH, 28'($urandom_range(2, 64)));
      endcase
      if ($urandom_range(0, 2) == 0)
        set_register(wtosc_pkg::REG_PHASE_INCREMENT, 28'($urandom));
      else
        set_register(wtosc_pkg::REG_PHASE_INCREMENT,
                     28'($urandom_range(0, active_length() << 16)));
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          play_sample();
        end else if ($urandom_range(0, 9) < 7) begin
          store_sample(12'($urandom_range(0, active_length() - 1)), 16'($urandom));
        end else begin
          store_sample(12'($urandom_range(0, 4095)), 16'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_burst_left > 0) begin
      m_tready <= 1'b0;
      rx_burst_left <= rx_burst_left - 1;
    end else if (rx_bursts_on && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      rx_burst_left <= $urandom_range(0, 14);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample: got %0d", $signed(m_tdata));
      end else begin
        want = samples_due.pop_front();
        if (m_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_out mismatch: expected %0d, got %0d", want, $signed(m_tdata));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_interpolation();
    test_length_limits();
    test_increment_clamp();
    test_phase_restart();
    test_output_stall();
    test_random_phases();
    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
